/* hdl/dfd_pkg.sv */
// Package for the dual format serial deframer.
// Holds the word types, frame kinds, end codes and marker bytes.
// Depends on nothing.
package dfd_pkg;

    localparam logic       OP_BYTE          = 1'b0;
    localparam logic       OP_IDLE          = 1'b1;

    localparam logic [7:0] START_A          = 8'h02;
    localparam logic [7:0] END_A            = 8'h03;
    localparam logic [7:0] START_B          = 8'h55;
    localparam logic [7:0] END_B            = 8'hAA;
    localparam logic [7:0] LEFT_IDLE        = 8'hFF;
    localparam logic [7:0] IDLE_LIMIT_RESET = 8'd100;

    localparam logic [8:0] LEN_POS_A        = 9'd2;
    localparam logic [8:0] LEN_POS_B        = 9'd1;
    localparam logic [7:0] LEN_ADD_A        = 8'd4;
    localparam logic [7:0] LEN_ADD_B        = 8'd3;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_A    = 2'd1,
        KIND_B    = 2'd2
    } t_frame_kind;

    typedef enum logic [1:0] {
        END_NONE    = 2'd0,
        END_GOOD    = 2'd1,
        END_BAD     = 2'd2,
        END_TIMEOUT = 2'd3
    } t_end_status;

    typedef struct packed {
        logic       op;
        logic [7:0] rx_byte;
    } t_in_word;

    typedef struct packed {
        logic       body_valid;
        logic       frame_start;
        logic [1:0] frame_type;
        logic [8:0] body_position;
        logic [7:0] body_byte;
        logic [1:0] end_status;
    } t_out_word;

endpackage

/* hdl/dual_format_uart_deframer.sv */
// Top level of the dual format serial deframer.
// Depends on dfd_pkg, dfd_in_stage and dfd_core.
//
//   Channel   Direction  Handshake                 Payload
//   in        input      i_in_valid / o_in_ready   i_in_word   (t_in_word)
//   out       output     o_out_valid / i_out_ready o_out_word  (t_out_word)
//   cfg       input      i_cfg_wr_en               i_cfg_wr_data (idle limit)
//
// Each word's result word passes through the input register and then the result register; one word
// is accepted every cycle while the output is not stalled, as the frame state is updated once per word.
// Reset is synchronous and clears the frame state and sets the idle limit to 100.
// A stalled output holds its result while the input register takes one more word.
module dual_format_uart_deframer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  dfd_pkg::t_in_word   i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output dfd_pkg::t_out_word  o_out_word,
    input  logic               i_cfg_wr_en,
    input  logic [7:0]         i_cfg_wr_data
);
    import dfd_pkg::*;

    logic     stage_valid;
    logic     stage_take;
    t_in_word stage_word;

    dfd_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_word  (i_in_word),
        .o_valid (stage_valid),
        .i_take  (stage_take),
        .o_word  (stage_word)
    );

    dfd_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (stage_valid),
        .o_take        (stage_take),
        .i_word        (stage_word),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_word    (o_out_word)
    );

endmodule

/* hdl/dfd_in_stage.sv */
// Input register of the deframer: holds one accepted word for the core.
// Depends on dfd_pkg.
module dfd_in_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  dfd_pkg::t_in_word i_word,
    output logic             o_valid,
    input  logic             i_take,
    output dfd_pkg::t_in_word o_word
);
    import dfd_pkg::*;

    logic     r_valid;
    t_in_word r_word;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= i_word;
        end
    end

endmodule

/* hdl/dfd_core.sv */
// Frame tracking state, per word step logic and the result register.
// Depends on dfd_pkg.
module dfd_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [7:0]        i_cfg_wr_data,
    input  logic              i_valid,
    output logic              o_take,
    input  dfd_pkg::t_in_word  i_word,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output dfd_pkg::t_out_word o_out_word
);
    import dfd_pkg::*;

    logic [7:0]  r_idle_limit;
    t_frame_kind r_open_kind, n_open_kind;
    logic [8:0]  r_bytes_seen, n_bytes_seen;
    logic [7:0]  r_bytes_left, n_bytes_left;
    logic [7:0]  r_idle_count, n_idle_count;
    logic        r_out_valid;
    t_out_word   r_out_word, n_out_word;

    logic        fire;
    logic [7:0]  idle_inc;
    logic [8:0]  len_pos;
    logic [7:0]  len_add;
    logic [7:0]  end_mark;
    logic [7:0]  left_load;

    assign o_take      = !r_out_valid || i_out_ready;
    assign fire        = i_valid && o_take;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;
    assign idle_inc    = r_idle_count + 8'd1;

    always_comb begin
        case (r_open_kind)
            KIND_A: begin
                len_pos  = LEN_POS_A;
                len_add  = LEN_ADD_A;
                end_mark = END_A;
            end
            default: begin
                len_pos  = LEN_POS_B;
                len_add  = LEN_ADD_B;
                end_mark = END_B;
            end
        endcase
    end

    assign left_load = (r_bytes_seen == len_pos) ? (i_word.rx_byte + len_add) : r_bytes_left;

    always_comb begin
        n_open_kind  = r_open_kind;
        n_bytes_seen = r_bytes_seen;
        n_bytes_left = r_bytes_left;
        n_idle_count = r_idle_count;
        n_out_word   = '0;
        if (i_word.op == OP_IDLE) begin
            if (r_open_kind != KIND_NONE) begin
                n_idle_count = idle_inc;
                if (idle_inc > r_idle_limit) begin
                    n_out_word.frame_type = r_open_kind;
                    n_out_word.end_status = END_TIMEOUT;
                    n_open_kind           = KIND_NONE;
                    n_bytes_seen          = '0;
                    n_bytes_left          = LEFT_IDLE;
                    n_idle_count          = '0;
                end
            end
        end else begin
            n_idle_count = '0;
            if (r_open_kind == KIND_NONE) begin
                case (i_word.rx_byte)
                    START_A: begin
                        n_open_kind            = KIND_A;
                        n_out_word.frame_start = 1'b1;
                        n_out_word.frame_type  = KIND_A;
                    end
                    START_B: begin
                        n_open_kind            = KIND_B;
                        n_out_word.frame_start = 1'b1;
                        n_out_word.frame_type  = KIND_B;
                    end
                    default: begin
                    end
                endcase
            end else begin
                n_out_word.frame_type    = r_open_kind;
                n_out_word.body_valid    = 1'b1;
                n_out_word.body_position = r_bytes_seen;
                n_out_word.body_byte     = i_word.rx_byte;
                n_bytes_left             = left_load - 8'd1;
                n_bytes_seen             = r_bytes_seen + 9'd1;
                if (n_bytes_left == 8'd0) begin
                    n_out_word.end_status = (i_word.rx_byte == end_mark) ? END_GOOD : END_BAD;
                    n_open_kind           = KIND_NONE;
                    n_bytes_seen          = '0;
                    n_bytes_left          = LEFT_IDLE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_limit <= IDLE_LIMIT_RESET;
        end else if (i_cfg_wr_en) begin
            r_idle_limit <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open_kind  <= KIND_NONE;
            r_bytes_seen <= '0;
            r_bytes_left <= LEFT_IDLE;
            r_idle_count <= '0;
        end else if (fire) begin
            r_open_kind  <= n_open_kind;
            r_bytes_seen <= n_bytes_seen;
            r_bytes_left <= n_bytes_left;
            r_idle_count <= n_idle_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_take) begin
            r_out_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_word <= n_out_word;
        end
    end

endmodule

/* bench/dual_format_uart_deframer_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the dual format serial deframer.
// Predicts every result word from its own frame tracker and checks the output stream.
// Depends on dfd_pkg and dual_format_uart_deframer.
module dual_format_uart_deframer_tb;
    import dfd_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_word    i_in_word;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_word   o_out_word;
    logic        i_cfg_wr_en;
    logic [7:0]  i_cfg_wr_data;

    t_frame_kind open_kind;
    logic [8:0]  bytes_seen;
    logic [7:0]  bytes_left;
    logic [7:0]  idle_count;
    logic [7:0]  idle_limit;

    t_out_word   pending_deframes[$];
    int          words_sent;
    int          error_count;
    bit          gaps_on;
    bit          stalls_on;

    dual_format_uart_deframer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_word     (i_in_word),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_word    (o_out_word),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic void close_tracked_frame();
        open_kind  = KIND_NONE;
        bytes_seen = 9'd0;
        bytes_left = LEFT_IDLE;
    endfunction

    function automatic t_out_word deframe_predict(t_in_word w);
        t_out_word  r;
        logic [8:0] len_pos;
        logic [7:0] len_add;
        logic [7:0] end_mark;
        r = '0;
        if (w.op == OP_IDLE) begin
            if (open_kind != KIND_NONE) begin
                idle_count = idle_count + 8'd1;
                if (idle_count > idle_limit) begin
                    r.frame_type = open_kind;
                    r.end_status = END_TIMEOUT;
                    close_tracked_frame();
                    idle_count = 8'd0;
                end
            end
        end else begin
            idle_count = 8'd0;
            if (open_kind == KIND_NONE) begin
                if (w.rx_byte == START_A) begin
                    open_kind = KIND_A;
                    r.frame_start = 1'b1;
                    r.frame_type = KIND_A;
                end else if (w.rx_byte == START_B) begin
                    open_kind = KIND_B;
                    r.frame_start = 1'b1;
                    r.frame_type = KIND_B;
                end
            end else begin
                len_pos  = (open_kind == KIND_A) ? LEN_POS_A : LEN_POS_B;
                len_add  = (open_kind == KIND_A) ? LEN_ADD_A : LEN_ADD_B;
                end_mark = (open_kind == KIND_A) ? END_A : END_B;
                r.frame_type    = open_kind;
                r.body_valid    = 1'b1;
                r.body_position = bytes_seen;
                r.body_byte     = w.rx_byte;
                if (bytes_seen == len_pos) begin
                    bytes_left = w.rx_byte + len_add;
                end
                bytes_left = bytes_left - 8'd1;
                bytes_seen = bytes_seen + 9'd1;
                if (bytes_left == 8'd0) begin
                    r.end_status = (w.rx_byte == end_mark) ? END_GOOD : END_BAD;
                    close_tracked_frame();
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input t_out_word want,
                                   input t_out_word got);
        error_count++;
        if (error_count <= 10) begin
            $display("%0s at %0t:", what, $realtime);
            $display("  expected v=%0d s=%0d t=%0d p=%0d b=%h e=%0d",
                     want.body_valid, want.frame_start, want.frame_type,
                     want.body_position, want.body_byte, want.end_status);
            $display("  got      v=%0d s=%0d t=%0d p=%0d b=%h e=%0d",
                     got.body_valid, got.frame_start, got.frame_type,
                     got.body_position, got.body_byte, got.end_status);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_out_word want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_deframes.size() == 0) begin
                report_mismatch("Unexpected word", '0, o_out_word);
            end else begin
                want = pending_deframes.pop_front();
                if (o_out_word.body_valid !== want.body_valid ||
                    o_out_word.frame_start !== want.frame_start ||
                    o_out_word.frame_type !== want.frame_type ||
                    o_out_word.body_position !== want.body_position ||
                    o_out_word.body_byte !== want.body_byte ||
                    o_out_word.end_status !== want.end_status) begin
                    report_mismatch("Mismatch", want, o_out_word);
                end
            end
        end
    end

    initial begin
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stalls_on && $urandom_range(0, 5) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
        end
    end

    task automatic send_word(input logic op, input logic [7:0] value);
        t_in_word w;
        w.op = op;
        w.rx_byte = value;
        i_in_valid <= 1'b1;
        i_in_word <= w;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_deframes.push_back(deframe_predict(w));
        words_sent++;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    task automatic send_idles(input int count);
        repeat (count) send_word(OP_IDLE, 8'($urandom));
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_deframes.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_idle_limit(input logic [7:0] value);
        drain();
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        idle_limit = value;
    endtask

    // The length byte sets how many body bytes follow it; the last one carries the end marker if good_end is set.
    task automatic send_frame(input t_frame_kind kind, input logic [7:0] len,
                              input bit good_end, input int idle_pct);
        int         len_pos;
        int         len_add;
        int         total;
        logic [7:0] end_mark;
        logic [7:0] b;
        len_pos  = (kind == KIND_A) ? int'(LEN_POS_A) : int'(LEN_POS_B);
        len_add  = (kind == KIND_A) ? int'(LEN_ADD_A) : int'(LEN_ADD_B);
        end_mark = (kind == KIND_A) ? END_A : END_B;
        total    = len_pos + 1 + ((int'(len) + len_add - 1) % 256);
        send_word(OP_BYTE, (kind == KIND_A) ? START_A : START_B);
        for (int i = 0; i < total; i++) begin
            if ($urandom_range(0, 99) < idle_pct) begin
                send_idles($urandom_range(1, 2));
            end
            if (i == len_pos) begin
                b = len;
            end else if (i == total - 1 && good_end) begin
                b = end_mark;
            end else if (i == total - 1) begin
                do b = 8'($urandom); while (b == end_mark);
            end else begin
                b = 8'($urandom);
            end
            send_word(OP_BYTE, b);
        end
    endtask

    task automatic test_directed_frames();
        write_idle_limit(IDLE_LIMIT_RESET);
        send_word(OP_BYTE, 8'h00);
        send_word(OP_BYTE, 8'hFF);
        send_word(OP_IDLE, 8'hFF);
        send_word(OP_BYTE, END_A);
        send_frame(KIND_A, 8'd0, 1'b1, 0);
        send_frame(KIND_B, 8'd0, 1'b0, 0);
        send_frame(KIND_B, 8'd254, 1'b1, 0);
        send_frame(KIND_A, 8'd253, 1'b1, 0);
    endtask

    task automatic test_idle_timeout();
        write_idle_limit(8'd0);
        send_idles(2);
        send_word(OP_BYTE, START_B);
        send_idles(1);
        write_idle_limit(8'd3);
        send_word(OP_BYTE, START_A);
        send_word(OP_BYTE, 8'h11);
        send_idles(3);
        send_word(OP_BYTE, 8'h22);
        send_idles(4);
        write_idle_limit(8'd255);
        send_word(OP_BYTE, START_A);
        send_idles(260);
        send_word(OP_BYTE, 8'h33);
        send_word(OP_BYTE, 8'd1);
        send_word(OP_BYTE, 8'h00);
        send_word(OP_BYTE, 8'h55);
        send_word(OP_BYTE, 8'h66);
        send_word(OP_BYTE, END_A);
    endtask

    task automatic test_length_wrap();
        write_idle_limit(8'd100);
        send_frame(KIND_A, 8'd252, 1'b1, 0);
        send_frame(KIND_B, 8'd253, 1'b0, 0);
        send_frame(KIND_B, 8'd255, 1'b1, 0);
    endtask

    task automatic test_random_traffic();
        int          target;
        int          pick;
        int          len_roll;
        logic [7:0]  limit;
        t_frame_kind kind;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: limit = 8'($urandom_range(0, 3));
                1: limit = 8'($urandom_range(4, 40));
                2: limit = 8'($urandom_range(0, 255));
                default: limit = IDLE_LIMIT_RESET;
            endcase
            write_idle_limit(limit);
            gaps_on = (phase < 3);
            stalls_on = (phase < 3);
            target = words_sent + 100;
            while (words_sent < target) begin
                pick = $urandom_range(0, 99);
                kind = $urandom_range(0, 1) ? KIND_A : KIND_B;
                if (pick < 70) begin
                    len_roll = $urandom_range(0, 99);
                    send_frame(kind,
                               (len_roll < 2) ? 8'($urandom) : 8'($urandom_range(0, 12)),
                               $urandom_range(0, 4) != 0, 10);
                end else if (pick < 82) begin
                    send_word(OP_BYTE, (kind == KIND_A) ? START_A : START_B);
                    repeat ($urandom_range(0, 4)) send_word(OP_BYTE, 8'($urandom));
                    send_idles((limit < 64) ? int'(limit) + 1 : $urandom_range(1, 3));
                end else begin
                    send_word(1'($urandom), 8'($urandom));
                end
            end
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_word <= '0;
        i_cfg_wr_en <= 1'b0;
        i_cfg_wr_data <= 8'd0;
        words_sent = 0;
        error_count = 0;
        gaps_on = 1'b1;
        stalls_on = 1'b1;
        idle_limit = IDLE_LIMIT_RESET;
        idle_count = 8'd0;
        close_tracked_frame();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_frames();
        test_idle_timeout();
        test_length_wrap();
        test_random_traffic();

        drain();
        if (error_count == 0 && pending_deframes.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

/* dual_format_uart_deframer.f */
hdl/dfd_pkg.sv
hdl/dfd_in_stage.sv
hdl/dfd_core.sv
hdl/dual_format_uart_deframer.sv
bench/dual_format_uart_deframer_tb.sv
